// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file fra_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define FRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked while reset is asserted.
`define FRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fra_pkg.sv =====
// Shared constants for the moving-average frame-rate meter.
// No dependencies.
package fra_pkg;

    localparam int DATA_W      = 32;
    localparam int RATE_W      = 22;
    localparam int ENTRIES_DEF = 16;

    // Q.8 rate numerator per filled slot: 1000 * 256.
    localparam int RATE_NUM_W  = 18;
    localparam logic [RATE_NUM_W-1:0] RATE_NUM = 18'd256000;

    localparam logic [RATE_W-1:0] RATE_MAX = 22'd4096000;

endpackage

// ===== hdl/fra_if.sv =====
// Handshake channels of the frame-rate meter: frame input, rate output, config write.
// Depends on fra_pkg.
interface fra_in_if;
    logic                        valid;
    logic                        ready;
    logic [fra_pkg::DATA_W-1:0]  now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface fra_out_if;
    logic                        valid;
    logic                        ready;
    logic [fra_pkg::RATE_W-1:0]  rate_q8;
    logic                        zero_sum;
    logic [fra_pkg::DATA_W-1:0]  interval_ms;

    modport source (output valid, output rate_q8, output zero_sum, output interval_ms,
                    input ready);
    modport sink   (input valid, input rate_q8, input zero_sum, input interval_ms,
                    output ready);
endinterface

interface fra_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fra_pkg::DATA_W-1:0]  start_ms;

    modport source (output valid, output start_ms, input ready);
    modport sink   (input valid, input start_ms, output ready);
endinterface

// ===== hdl/moving_average_frame_rate.sv =====
// Top level of the moving-average frame-rate meter: control, ring store, divider.
// Depends on fra_pkg, fra_if, fra_ring, fra_div.
//
//  channel    dir  payload                               handshake
//  frame_in   in   now_ms[31:0]                          valid/ready
//  rate_out   out  rate_q8[21:0] zero_sum interval_ms    valid/ready
//  cfg        in   start_ms[31:0]                        valid/ready (ready tied high)
//
// A frame runs through read, calc, divide and hold (NUM_W = 18 + count width: 23 at 16 entries);
// the serial divider works through all NUM_W numerator bits. A zero sum skips the divider.
// Ring read and write-back happen in separate states of one frame, so accesses never overlap.
// The ring needs no clearing after reset: until all slots are filled, the read slot is
// one never written and is taken as zero. A next frame is accepted while a result waits.
module moving_average_frame_rate #(
    parameter int ENTRIES = fra_pkg::ENTRIES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    fra_in_if.sink     frame_in,
    fra_out_if.source  rate_out,
    fra_cfg_if.sink    cfg
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SUM_W  = fra_pkg::DATA_W + CNT_W;
    localparam int NUM_W  = fra_pkg::RATE_NUM_W + CNT_W;
    localparam int CMP_W  = (NUM_W > fra_pkg::RATE_W) ? NUM_W : fra_pkg::RATE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [fra_pkg::DATA_W-1:0]  start_ms_reg;
    logic [fra_pkg::DATA_W-1:0]  prev_reg;
    logic                        tick_valid_reg;
    logic [fra_pkg::DATA_W-1:0]  interval_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [fra_pkg::RATE_W-1:0]  res_rate_reg;
    logic                        res_zero_reg;
    logic                        out_valid_reg;
    logic [fra_pkg::RATE_W-1:0]  out_rate_reg;
    logic                        out_zero_reg;
    logic [fra_pkg::DATA_W-1:0]  out_interval_reg;

    logic                        in_fire;
    logic                        out_free;
    logic [fra_pkg::DATA_W-1:0]  prev;
    logic [fra_pkg::DATA_W-1:0]  ring_rdata;
    logic [fra_pkg::DATA_W-1:0]  old_interval;
    logic                        ring_full;
    logic [SUM_W-1:0]            sum_next;
    logic                        div_start;
    logic [NUM_W-1:0]            div_numer;
    logic                        div_done;
    logic [NUM_W-1:0]            div_quot;
    logic [fra_pkg::RATE_W-1:0]  rate_clamped;

    assign in_fire  = frame_in.valid && frame_in.ready;
    assign out_free = !out_valid_reg || rate_out.ready;
    assign prev     = tick_valid_reg ? prev_reg : start_ms_reg;

    assign frame_in.ready = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;

    // Slots are written in order, so an unfilled ring reads a never-written slot.
    assign ring_full    = (count_reg == CNT_W'(ENTRIES));
    assign old_interval = ring_full ? ring_rdata : '0;
    assign sum_next     = sum_reg - SUM_W'(old_interval) + SUM_W'(interval_reg);

    assign div_start = (state_reg == S_CALC) && (sum_reg != '0);
    assign div_numer = NUM_W'(fra_pkg::RATE_NUM) * NUM_W'(count_reg);

    assign rate_clamped = (CMP_W'(div_quot) > CMP_W'(fra_pkg::RATE_MAX))
                        ? fra_pkg::RATE_MAX : div_quot[fra_pkg::RATE_W-1:0];

    fra_ring #(
        .DEPTH  (ENTRIES),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .clk    (clk),
        .we     (state_reg == S_READ),
        .waddr  (slot_reg),
        .wdata  (interval_reg),
        .re     (in_fire),
        .raddr  (slot_reg),
        .rdata  (ring_rdata)
    );

    fra_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_READ;
            S_READ: state_next = S_CALC;
            S_CALC: state_next = (sum_reg == '0) ? S_HOLD : S_DIV;
            S_DIV:  if (div_done) state_next = S_HOLD;
            S_HOLD: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_ms_reg   <= '0;
            tick_valid_reg <= 1'b0;
            slot_reg       <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                start_ms_reg <= cfg.start_ms;
            end
            if (in_fire)
            begin
                tick_valid_reg <= 1'b1;
            end
            if (state_reg == S_READ)
            begin
                sum_reg  <= sum_next;
                slot_reg <= (slot_reg == SLOT_W'(ENTRIES - 1)) ? '0 : slot_reg + 1'b1;
                if (!ring_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if ((state_reg == S_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rate_out.valid && rate_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            interval_reg <= frame_in.now_ms - prev;
            prev_reg     <= frame_in.now_ms;
        end
        if ((state_reg == S_CALC) && (sum_reg == '0))
        begin
            res_rate_reg <= fra_pkg::RATE_MAX;
            res_zero_reg <= 1'b1;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            res_rate_reg <= rate_clamped;
            res_zero_reg <= 1'b0;
        end
        if ((state_reg == S_HOLD) && out_free)
        begin
            out_rate_reg     <= res_rate_reg;
            out_zero_reg     <= res_zero_reg;
            out_interval_reg <= interval_reg;
        end
    end

    assign rate_out.valid       = out_valid_reg;
    assign rate_out.rate_q8     = out_rate_reg;
    assign rate_out.zero_sum    = out_zero_reg;
    assign rate_out.interval_ms = out_interval_reg;

endmodule

// ===== hdl/fra_ring.sv =====
// Interval ring store: one write port, one read port, registered read data.
// Depends on fra_pkg.
module fra_ring #(
    parameter int DEPTH  = fra_pkg::ENTRIES_DEF,
    parameter int ADDR_W = 4
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [fra_pkg::DATA_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [fra_pkg::DATA_W-1:0]  rdata
);

    logic [fra_pkg::DATA_W-1:0] mem_reg [DEPTH];
    logic [fra_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fra_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on fra_pkg only through its users; no package items used here.
module fra_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 37
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;

    // Numerator bits shift out at the top while quotient bits shift in below.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], qbit};
            rem_reg <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ===== hdl/fra_checker.sv =====
// Port-level checks for the frame-rate meter, bound to the top level.
// Depends on fra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fra_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [fra_pkg::RATE_W-1:0]  rate_q8,
    input  logic                        zero_sum
);

    logic rate_at_max;

    assign rate_at_max = (rate_q8 == fra_pkg::RATE_MAX);

    // A beat offered on the output is not withdrawn before it is taken.
    `FRA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output beat dropped")

    // A zero sum always comes with the saturated rate.
    `FRA_ASSERT(a_zero_sat, out_valid && zero_sum |-> rate_at_max, "zero sum, rate not max")

    // The rate never passes its ceiling.
    `FRA_ASSERT(a_rate_max, out_valid |-> rate_q8 <= fra_pkg::RATE_MAX, "rate above maximum")

    // One frame at a time: the input closes right after a beat is taken.
    `FRA_ASSERT(a_one_frame, in_valid && in_ready |=> !in_ready, "input open during a frame")

    // Reset clears the output valid by the next edge.
    `FRA_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "output valid in reset")

endmodule

bind moving_average_frame_rate fra_checker u_fra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame_in.valid),
    .in_ready  (frame_in.ready),
    .out_valid (rate_out.valid),
    .out_ready (rate_out.ready),
    .rate_q8   (rate_out.rate_q8),
    .zero_sum  (rate_out.zero_sum)
);

// ===== tb/sv/tb_moving_average_frame_rate.sv =====
`timescale 1ns / 1ps
// Self-checking bench for moving_average_frame_rate: drives frame timestamps and
// start_ms writes, predicts rate/interval beats in a scoreboard and compares them.
// Depends on fra_pkg and the fra_in_if / fra_out_if / fra_cfg_if interfaces.
module tb_moving_average_frame_rate;

    localparam int ENTRIES = fra_pkg::ENTRIES_DEF;

    typedef struct packed {
        logic [fra_pkg::RATE_W-1:0] rate_q8;
        logic                       zero_sum;
        logic [fra_pkg::DATA_W-1:0] interval_ms;
    } rate_beat_t;

    class rate_scoreboard;
        logic [fra_pkg::DATA_W-1:0] start_ms;
        logic [fra_pkg::DATA_W-1:0] last_tick;
        bit                         tick_seen;
        logic [fra_pkg::DATA_W-1:0] intervals [ENTRIES];
        int unsigned                slot;
        int unsigned                filled;
        logic [63:0]                interval_total;
        rate_beat_t                 pending_rates [$];
        int unsigned                errors;

        function new();
            start_ms       = '0;
            last_tick      = '0;
            tick_seen      = 1'b0;
            slot           = 0;
            filled         = 0;
            interval_total = '0;
            errors         = 0;
            foreach (intervals[i])
                intervals[i] = '0;
        endfunction

        function void set_start(logic [fra_pkg::DATA_W-1:0] value);
            start_ms = value;
        endfunction

        function void note_frame(logic [fra_pkg::DATA_W-1:0] now_ms);
            logic [fra_pkg::DATA_W-1:0] origin;
            logic [63:0]                quotient;
            rate_beat_t                 beat;
            origin = tick_seen ? last_tick : start_ms;
            beat.interval_ms = now_ms - origin;
            interval_total = interval_total - intervals[slot] + beat.interval_ms;
            intervals[slot] = beat.interval_ms;
            last_tick = now_ms;
            tick_seen = 1'b1;
            slot = (slot + 1) % ENTRIES;
            if (filled < ENTRIES)
                filled++;
            if (interval_total == 0)
            begin
                beat.rate_q8  = fra_pkg::RATE_MAX;
                beat.zero_sum = 1'b1;
            end
            else
            begin
                quotient = (64'(fra_pkg::RATE_NUM) * 64'(filled)) / interval_total;
                if (quotient > 64'(fra_pkg::RATE_MAX))
                    quotient = 64'(fra_pkg::RATE_MAX);
                beat.rate_q8  = quotient[fra_pkg::RATE_W-1:0];
                beat.zero_sum = 1'b0;
            end
            pending_rates.push_back(beat);
        endfunction

        function void check_beat(rate_beat_t got);
            rate_beat_t want;
            if (pending_rates.size() == 0)
            begin
                $error("unexpected rate beat: rate_q8=%0d zero_sum=%0d interval_ms=%0d",
                       got.rate_q8, got.zero_sum, got.interval_ms);
                errors++;
                return;
            end
            want = pending_rates.pop_front();
            if (got.rate_q8 !== want.rate_q8)
            begin
                $error("rate_q8 expected %0d got %0d", want.rate_q8, got.rate_q8);
                errors++;
            end
            if (got.zero_sum !== want.zero_sum)
            begin
                $error("zero_sum expected %0d got %0d", want.zero_sum, got.zero_sum);
                errors++;
            end
            if (got.interval_ms !== want.interval_ms)
            begin
                $error("interval_ms expected %0d got %0d", want.interval_ms, got.interval_ms);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_rates.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic calm = 1'b0;
    logic [fra_pkg::DATA_W-1:0] last_stamp = '0;
    rate_scoreboard sb;

    fra_in_if  frame_in ();
    fra_out_if rate_out ();
    fra_cfg_if cfg ();

    moving_average_frame_rate #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame_in(frame_in.sink),
        .rate_out(rate_out.source),
        .cfg     (cfg.sink)
    );

    always #5 clk = ~clk;

    // valid stays up across back-to-back writes; caller drops it after the batch
    task automatic write_start(logic [fra_pkg::DATA_W-1:0] value);
        cfg.valid    <= 1'b1;
        cfg.start_ms <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.set_start(value);
    endtask

    task automatic send_frame(logic [fra_pkg::DATA_W-1:0] stamp);
        while (!calm && $urandom_range(99) < 28)
        begin
            frame_in.valid <= 1'b0;
            @(posedge clk);
        end
        frame_in.valid  <= 1'b1;
        frame_in.now_ms <= stamp;
        @(posedge clk);
        while (!frame_in.ready)
            @(posedge clk);
        sb.note_frame(stamp);
        last_stamp = stamp;
    endtask

    // sender holds off until every predicted beat is back
    task automatic drain();
        frame_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned pick;
        int unsigned zero_run;
        logic [fra_pkg::DATA_W-1:0] stamp;
        zero_run = 0;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (zero_run > 0)
            begin
                zero_run--;
                stamp = last_stamp;
            end
            else if (pick < 40)
                stamp = last_stamp + $urandom_range(50, 1);
            else if (pick < 55)
                stamp = last_stamp + $urandom_range(1000, 51);
            else if (pick < 65)
                stamp = last_stamp + $urandom_range(32'h10_0000, 1);
            else if (pick < 75)
                stamp = $urandom;
            else if (pick < 85)
                stamp = last_stamp;
            else if (pick < 90)
            begin
                // long run of repeats empties the sum back to zero
                zero_run = ENTRIES + $urandom_range(3);
                stamp = last_stamp;
            end
            else if (pick < 95)
                stamp = last_stamp - $urandom_range(8, 1);
            else
                stamp = last_stamp + 32'hFFFF_FFFF;
            send_frame(stamp);
        end
    endtask

    initial
    begin
        rate_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rate_out.valid && rate_out.ready)
                sb.check_beat({rate_out.rate_q8, rate_out.zero_sum, rate_out.interval_ms});
            rate_out.ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    initial
    begin
        sb = new();
        frame_in.valid  <= 1'b0;
        frame_in.now_ms <= '0;
        cfg.valid       <= 1'b0;
        cfg.start_ms    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // last write before the first frame is the one that counts
        write_start('0);
        write_start($urandom);
        write_start(32'hFFFF_FFFF);
        cfg.valid <= 1'b0;

        // zero intervals until the ring is full, sum stays zero
        repeat (ENTRIES) send_frame(32'hFFFF_FFFF);
        send_frame(32'h0000_0000);     // wraps to interval 1: full ring, rate at max
        send_frame(32'hFFFF_FFFF);     // largest interval
        send_frame(32'h8000_0000);
        send_frame(32'h8000_03E8);
        drain();

        // start_ms writes after the first frame must have no effect
        write_start('0);
        cfg.valid <= 1'b0;
        run_random(233);
        drain();

        write_start(32'hFFFF_FFFF);
        cfg.valid <= 1'b0;
        calm = 1'b1;
        run_random(233);
        calm = 1'b0;
        drain();

        write_start($urandom);
        cfg.valid <= 1'b0;
        run_random(233);
        drain();

        write_start($urandom);
        cfg.valid <= 1'b0;
        run_random(233);
        drain();

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fra_pkg.sv
hdl/fra_if.sv
hdl/fra_ring.sv
hdl/fra_div.sv
hdl/moving_average_frame_rate.sv
hdl/fra_checker.sv
tb/sv/tb_moving_average_frame_rate.sv
